// ===== src/ltc_pkg.sv =====
package ltc_pkg;

  // storage geometry
  localparam int ENTRIES     = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NUM_W       = $clog2(ENTRIES + 1);

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int TAG_W  = 2 * KEY_W;
  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;

  localparam logic [CFG_W-1:0]       CFG_RESET = CFG_W'(64);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

// ===== src/ltc_if.sv =====
// request channel
interface ltc_req_if;
  import ltc_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] first_key;
  logic [KEY_W-1:0] second_key;
  modport source (output valid, opcode, first_key, second_key, input ready);
  modport sink   (input valid, opcode, first_key, second_key, output ready);
endinterface

// response channel
interface ltc_rsp_if;
  import ltc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, hit, slot, input ready);
  modport sink   (input valid, hit, slot, output ready);
endinterface

// configuration write channel
interface ltc_cfg_if;
  import ltc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/ltc_ram.sv =====
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lfu_tag_cache_lookup.sv =====
// channel  modport  beat contents
// -------  -------  ------------------------------------------------
// cfg      sink     data: entries_in_use (7 bits), always ready
// req      sink     opcode, first_key, second_key
// rsp      source   hit, slot (one beat per find, none per flush)
//
// a find scans the active slots in order from slot 0 and stops at a hit or at
// the last active slot; the response comes out of the write-back, and no new request
// is taken until then; one slot per cycle is read from the tag and count
// memories, one read port each
// a flush is taken in the idle state; it clears the per-slot valid bits
// reset clears those valid bits at once, so no clearing pass is needed
// a held response stalls the final write-back until rsp is taken
module lfu_tag_cache_lookup (
  input logic clk,
  input logic rst,
  ltc_cfg_if.sink   cfg,
  ltc_req_if.sink   req,
  ltc_rsp_if.source rsp
);
  import ltc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]             state;
  logic [CFG_W-1:0]       entries_in_use;
  logic [ENTRIES-1:0]     valid_bits;
  logic [KEY_W-1:0]       key1;
  logic [KEY_W-1:0]       key2;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       iss;
  logic [IDX_W-1:0]       pidx;
  logic                   pv;
  logic [IDX_W-1:0]       victim;
  logic [COUNT_WIDTH-1:0] vcnt;
  logic                   found;
  logic [IDX_W-1:0]       hidx;
  logic [COUNT_WIDTH-1:0] hcnt;
  logic                   out_valid;
  logic                   out_hit;
  logic [SLOT_W-1:0]      out_slot;

  logic [TAG_W-1:0]       tag_rdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic                   match;
  logic [NUM_W-1:0]       n_act;
  logic                   wb_go;
  logic [IDX_W-1:0]       wb_addr;
  logic [COUNT_WIDTH-1:0] wb_cnt;
  logic                   req_take;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_RESET;
    end else if (cfg.valid) begin
      entries_in_use <= cfg.data;
    end
  end

  // active slot count, zero taken as one and clamped to the store size
  always_comb begin
    if (entries_in_use == '0) begin
      n_act = NUM_W'(1);
    end else if (32'(entries_in_use) > ENTRIES) begin
      n_act = NUM_W'(ENTRIES);
    end else begin
      n_act = NUM_W'(entries_in_use);
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;

  // per-slot comparison on the data read last cycle
  assign cnt_eff = valid_bits[pidx] ? cnt_rdata : '0;
  assign match   = (cnt_eff != '0) && (tag_rdata == {key1, key2});

  // write-back once the response register is free
  assign wb_go   = (state == ST_FINISH) && (!out_valid || rsp.ready);
  assign wb_addr = found ? hidx : victim;
  assign wb_cnt  = found ? ((hcnt == COUNT_MAX) ? hcnt : hcnt + 1'b1)
                         : COUNT_WIDTH'(1);

  ltc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (wb_go && !found),
    .waddr (wb_addr),
    .wdata ({key1, key2}),
    .raddr (iss),
    .rdata (tag_rdata)
  );

  ltc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (wb_go),
    .waddr (wb_addr),
    .wdata (wb_cnt),
    .raddr (iss),
    .rdata (cnt_rdata)
  );

  // sequencer and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      pv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (req.opcode == OP_FLUSH) begin
              valid_bits <= '0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pv && (match || pidx == last_idx)) begin
            pv    <= 1'b0;
            state <= ST_FINISH;
          end else begin
            pv <= 1'b1;
          end
        end
        ST_FINISH: begin
          if (wb_go) begin
            valid_bits[wb_addr] <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_take) begin
      key1     <= req.first_key;
      key2     <= req.second_key;
      last_idx <= IDX_W'(n_act - 1'b1);
      iss      <= '0;
      found    <= 1'b0;
    end
    if (state == ST_SCAN) begin
      iss  <= iss + 1'b1;
      pidx <= iss;
      if (pv) begin
        if (match) begin
          found <= 1'b1;
          hidx  <= pidx;
          hcnt  <= cnt_eff;
        end else if (pidx == '0 || cnt_eff < vcnt) begin
          victim <= pidx;
          vcnt   <= cnt_eff;
        end
      end
    end
    if (wb_go) begin
      out_hit  <= found;
      out_slot <= SLOT_W'(wb_addr);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hit   = out_hit;
  assign rsp.slot  = out_slot;

  // a flush leaves every slot empty
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.opcode == OP_FLUSH) |=> valid_bits == '0)
    else $error("flush did not clear valid bits");

  // a new response only comes out of the write-back step
  a_rsp_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_FINISH)
    else $error("response raised outside write-back");

  // the scan never looks past the active slots
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && pv |-> pidx <= last_idx)
    else $error("scan index beyond active slots");

  // the written slot is always marked in use
  a_wb_marks: assert property (@(posedge clk) disable iff (rst)
    wb_go |=> valid_bits[$past(wb_addr)] && rsp.valid)
    else $error("write-back did not mark slot");

endmodule
